FILE: hw/rtl/sktu_pkg.sv
// Shared types and codes for the sorted key table upsert block.
package sktu_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned ROLE_W = 32;
  localparam int unsigned MASK_W = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index decoded from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic KIND_UPSERT = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ROLE_W-1:0] role;
    logic [MASK_W-1:0] mask;
  } rec_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp;
    logic             upd;
    logic             ins;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/sktu_if.sv
// Request and response channel interfaces of the sorted key table.
interface sktu_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] agent_key;
  logic [31:0] role_value;
  logic [31:0] action_mask;

  modport source (output valid, kind, agent_key, role_value, action_mask, input ready);
  modport sink   (input valid, kind, agent_key, role_value, action_mask, output ready);
endinterface

interface sktu_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] slot_position;
  logic       was_present;
  logic [4:0] entries_used;

  modport source (output valid, status, slot_position, was_present, entries_used,
                  input ready);
  modport sink   (input valid, status, slot_position, was_present, entries_used,
                  output ready);
endinterface

FILE: hw/rtl/sorted_key_table_upsert_top.sv
// Top level of the sorted key table with insert-or-update, built as a row of cells.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  req_i    | in  | valid / ready    | kind, agent_key, role_value, action_mask
//  rsp_o    | out | valid / ready    | status, slot_position, was_present,
//           |     |                  | entries_used
//  APB      | in  | psel / penable   | paddr, pwdata, prdata (capacity_limit)
//
// On acceptance every cell compares its key with the request key in parallel
// and registers the flags; in the commit state the cells update in place or
// shift up by one to make room. A new request is taken once the
// previous one has committed. The result sits in an output register, so a
// request may be accepted while an earlier result waits; a stalled response
// holds the commit cycle. Reset empties the table at once (no clearing pass)
// and sets capacity_limit to 16.
module sorted_key_table_upsert_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sktu_req_if.sink                      req_i,
  sktu_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sktu_pkg::ADDR_W-1:0]   paddr,
  input  logic [sktu_pkg::DATA_W-1:0]   pwdata,
  output logic [sktu_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import sktu_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  // common width for count, capacity and slot arithmetic
  localparam int unsigned CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CW-1:0] DEPTH_CW = CW'(TABLE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [CAP_W-1:0] cap_q;
  logic             kind_q;
  rec_t             item_q;

  logic             req_fire;
  logic             rsp_free;
  logic             commit;

  cell_ctrl_t       ctrl;
  rec_t             rec    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] live_vec;
  logic [TABLE_DEPTH:0]   bnd_vec;

  logic [CW-1:0]    count_cw;
  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    pos;
  logic             found;
  logic             full;
  logic             do_ins;

  // Configuration port: pready is tied high, reads return the register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = DATA_W'(cap_q);
    end
  end

  // Sequencer: accept, then commit once the output register is free.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_o.valid || rsp_o.ready;
  assign commit      = (state_q == S_COMMIT) && rsp_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_fire) state_d = S_COMMIT;
      S_COMMIT: if (commit)   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hold the request payload for the commit cycle
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q      <= req_i.kind;
      item_q.key  <= req_i.agent_key;
      item_q.role <= req_i.role_value;
      item_q.mask <= req_i.action_mask;
    end
  end

  // Row of cells. Cell 0 sees a virtual neighbour below every key.
  assign ctrl.cmp = req_fire;
  assign ctrl.key = req_i.agent_key;
  assign ctrl.upd = commit && (kind_q == KIND_UPSERT) && found;
  assign ctrl.ins = do_ins;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign live_vec[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      sktu_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .item_i      (item_q),
        .live_i      (live_vec[i]),
        .prev_live_i (1'b0),
        .prev_lt_i   (1'b1),
        .prev_rec_i  (item_q),
        .rec_o       (rec[i]),
        .lt_o        (lt_vec[i]),
        .eq_o        (eq_vec[i])
      );
    end else begin : g_next
      sktu_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .item_i      (item_q),
        .live_i      (live_vec[i]),
        .prev_live_i (live_vec[i-1]),
        .prev_lt_i   (lt_vec[i-1]),
        .prev_rec_i  (rec[i-1]),
        .rec_o       (rec[i]),
        .lt_o        (lt_vec[i]),
        .eq_o        (eq_vec[i])
      );
    end
  end

  // Slot is the first place whose key is not below the request key: the
  // edge of the thermometer formed by the less-than flags.
  always_comb begin
    bnd_vec[0] = !lt_vec[0];
    for (int j = 1; j < TABLE_DEPTH; j++) begin
      bnd_vec[j] = lt_vec[j-1] && !lt_vec[j];
    end
    bnd_vec[TABLE_DEPTH] = lt_vec[TABLE_DEPTH-1];
  end

  always_comb begin
    pos = '0;
    for (int j = 0; j <= TABLE_DEPTH; j++) begin
      pos = pos | (bnd_vec[j] ? CW'(j) : '0);
    end
  end

  assign found    = |eq_vec;
  assign count_cw = CW'(count_q);
  assign eff_cap  = (CW'(cap_q) > DEPTH_CW) ? DEPTH_CW : CW'(cap_q);
  assign full     = (count_cw >= eff_cap);
  assign do_ins   = commit && (kind_q == KIND_UPSERT) && !found && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit && (kind_q == KIND_CLEAR)) begin
      count_q <= '0;
    end else if (do_ins) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Output register: advance on commit, drop valid when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_o.valid <= 1'b0;
    end else if (commit) begin
      rsp_o.valid <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (kind_q == KIND_CLEAR) begin
        rsp_o.status        <= ST_CLEARED;
        rsp_o.slot_position <= '0;
        rsp_o.was_present   <= 1'b0;
        rsp_o.entries_used  <= '0;
      end else if (found) begin
        rsp_o.status        <= ST_UPDATED;
        rsp_o.slot_position <= pos[SLOT_W-1:0];
        rsp_o.was_present   <= 1'b1;
        rsp_o.entries_used  <= count_cw[SLOT_W-1:0];
      end else if (full) begin
        rsp_o.status        <= ST_REJECTED;
        rsp_o.slot_position <= pos[SLOT_W-1:0];
        rsp_o.was_present   <= 1'b0;
        rsp_o.entries_used  <= count_cw[SLOT_W-1:0];
      end else begin
        rsp_o.status        <= ST_INSERTED;
        rsp_o.slot_position <= pos[SLOT_W-1:0];
        rsp_o.was_present   <= 1'b0;
        rsp_o.entries_used  <= SLOT_W'(count_cw + CW'(1));
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(count_q) <= DEPTH_CW)
    else $error("entry count beyond table depth");

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> $onehot0(eq_vec))
    else $error("key matched in more than one slot");

  a_edge_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> $onehot(bnd_vec))
    else $error("slot edge not unique, table out of order");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (kind_q == KIND_UPSERT) && !found && full) |=> $stable(count_q))
    else $error("rejected request changed the count");
`endif

endmodule

FILE: hw/rtl/sktu_cell.sv
// One table slot: holds a record, compares it and shifts from its lower neighbour.
module sktu_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sktu_pkg::cell_ctrl_t ctrl_i,
  input  sktu_pkg::rec_t     item_i,
  input  logic               live_i,
  input  logic               prev_live_i,
  input  logic               prev_lt_i,
  input  sktu_pkg::rec_t     prev_rec_i,
  output sktu_pkg::rec_t     rec_o,
  output logic               lt_o,
  output logic               eq_o
);
  import sktu_pkg::*;

  rec_t rec_q;
  logic lt_q;
  logic eq_q;

  // capture compare flags against the incoming key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      lt_q <= live_i && (rec_q.key < ctrl_i.key);
      eq_q <= live_i && (rec_q.key == ctrl_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd && eq_q) begin
      rec_q.role <= item_i.role;
      rec_q.mask <= item_i.mask;
    end else if (ctrl_i.ins) begin
      if (prev_lt_i && !lt_q) begin
        rec_q <= item_i;
      end else if (prev_live_i && !prev_lt_i) begin
        rec_q <= prev_rec_i;
      end
    end
  end

  assign rec_o = rec_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table: directed and random requests against a shadow table.
module tb;
  import sktu_pkg::*;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned MAX_GAP         = 6;
  // capacity_limit is register 0, decoded from paddr[2]
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  // Capacity per random phase. The table is kept across phases, so a low value
  // after a full one exercises the case of a capacity below the entry count.
  localparam int unsigned PHASE_CAPS [PHASES] = '{16, 31, 3, 0, 16, 1, 2, 12, 5, 16, 15, 8};

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic               present;
    logic [CAP_W-1:0]   used;
  } table_result_t;

  // Shadow of the key table. Role and mask never reach the response, so only
  // the ordered keys and the entry count are tracked.
  class table_shadow;
    logic [KEY_W-1:0] keys [DEPTH];
    int unsigned      used_count;
    int unsigned      capacity;
    table_result_t    pending_results [$];
    int unsigned      mismatches;

    function new();
      used_count = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void note_request(logic kind, logic [KEY_W-1:0] key);
      table_result_t res;
      int unsigned   pos;
      int unsigned   cap;
      int unsigned   i;
      bit            found;
      res.status  = ST_CLEARED;
      res.slot    = '0;
      res.present = 1'b0;
      res.used    = '0;
      if (kind == KIND_CLEAR) begin
        used_count = 0;
      end else begin
        pos = 0;
        while (pos < used_count && keys[pos] < key) pos++;
        found    = (pos < used_count) && (keys[pos] == key);
        cap      = (capacity > DEPTH) ? DEPTH : capacity;
        res.slot = SLOT_W'(pos);
        if (found) begin
          res.status  = ST_UPDATED;
          res.present = 1'b1;
        end else if (used_count >= cap) begin
          res.status = ST_REJECTED;
        end else begin
          for (i = used_count; i > pos; i--) keys[i] = keys[i-1];
          keys[pos] = key;
          used_count++;
          res.status = ST_INSERTED;
        end
        res.used = CAP_W'(used_count);
      end
      pending_results.push_back(res);
    endfunction

    function void check_response(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d slot %0d",
                 $time, got.status, got.slot);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot_position expected %0d actual %0d", $time, want.slot, got.slot);
        mismatches++;
      end
      if (got.present !== want.present) begin
        $display("%0t: was_present expected %0d actual %0d", $time, want.present, got.present);
        mismatches++;
      end
      if (got.used !== want.used) begin
        $display("%0t: entries_used expected %0d actual %0d", $time, want.used, got.used);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int unsigned       cycle_count = 0;
  table_shadow       shadow;
  logic [KEY_W-1:0]  key_pool [$];

  sktu_req_if req_ch ();
  sktu_rsp_if rsp_ch ();

  sorted_key_table_upsert_top #(
    .TABLE_DEPTH (DEPTH)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Guard against a hung handshake: abandon the run at a generous cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until the block takes it.
  // Valid is only lowered when a gap follows, so a back-to-back stream keeps it
  // high without a second assignment in the same step.
  task automatic push_request(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [ROLE_W-1:0] role,
                              input logic [MASK_W-1:0] mask, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.agent_key   <= key;
    req_ch.role_value  <= role;
    req_ch.action_mask <= mask;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    shadow.note_request(kind, key);
  endtask

  // Drain every outstanding response, let the commit cycle settle, then write
  // capacity_limit over APB and read it straight back.
  task automatic set_capacity(input int unsigned value);
    req_ch.valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow.capacity = value;
    // keep psel high and go straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DATA_W'(value)) begin
      $display("%0t: capacity_limit read expected %0d actual %0d", $time, value, prdata);
      shadow.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Bias role and mask towards their extremes now and then.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Build a small key set so that upserts hit existing records often and the
  // table fills up; mix in keys near both ends and adjacent neighbours.
  task automatic build_key_pool();
    int unsigned pool_size;
    int unsigned j;
    key_pool.delete();
    pool_size = $urandom_range(4, 28);
    for (j = 0; j < pool_size; j++) begin
      case ($urandom_range(0, 3))
        0:       key_pool.push_back(KEY_W'($urandom_range(0, 40)));
        1:       key_pool.push_back('1 - KEY_W'($urandom_range(0, 40)));
        2:       key_pool.push_back(j > 0 ? key_pool[j-1] + 1'b1 : '0);
        default: key_pool.push_back(random_key());
      endcase
    end
  endtask

  // Response side: random ready stalls, stretches with none, and two long
  // hold-offs that back the block up until it refuses further requests.
  initial begin
    int unsigned   wait_cycles;
    int unsigned   taken;
    table_result_t got;
    rsp_ch.ready = 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken == 300 || taken == 1100) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      wait_cycles = ((taken / 200) % 2 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      got.status  = status_e'(rsp_ch.status);
      got.slot    = rsp_ch.slot_position;
      got.present = rsp_ch.was_present;
      got.used    = rsp_ch.entries_used;
      shadow.check_response(got);
      taken++;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned n;
    bit          no_gap;
    shadow             = new();
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_UPSERT;
    req_ch.agent_key   = '0;
    req_ch.role_value  = '0;
    req_ch.action_mask = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear on an empty table, keys at both extremes, updates in
    // place, inserts in the middle, then a capacity below the count and zero.
    push_request(KIND_CLEAR, '1, '1, '1, 1'b0);
    push_request(KIND_UPSERT, '0, '0, '0, 1'b0);
    push_request(KIND_UPSERT, '1, '1, '1, 1'b1);
    push_request(KIND_UPSERT, '0, '1, '1, 1'b1);
    push_request(KIND_UPSERT, 64'h8000_0000_0000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    push_request(KIND_UPSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    push_request(KIND_UPSERT, '1, '0, '0, 1'b1);
    push_request(KIND_UPSERT, 64'd1, 32'd7, 32'd9, 1'b0);
    set_capacity(2);
    push_request(KIND_UPSERT, '1, 32'd3, 32'd4, 1'b0);
    push_request(KIND_UPSERT, 64'd2, 32'd3, 32'd4, 1'b0);
    set_capacity(0);
    push_request(KIND_UPSERT, '0, 32'd1, 32'd1, 1'b0);
    push_request(KIND_UPSERT, 64'h10, 32'd1, 32'd1, 1'b0);
    push_request(KIND_CLEAR, '0, '0, '0, 1'b0);
    push_request(KIND_UPSERT, 64'd5, 32'd1, 32'd1, 1'b0);
    set_capacity(31);
    push_request(KIND_UPSERT, 64'd9, 32'd2, 32'd2, 1'b0);

    // Random phases: mostly keys from a small set, some noise keys and the odd
    // clear. Every fourth phase runs without sender gaps.
    for (ph = 0; ph < PHASES; ph++) begin
      set_capacity(PHASE_CAPS[ph]);
      build_key_pool();
      no_gap = (ph % 4 == 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 59) == 0) begin
          push_request(KIND_CLEAR, random_key(), $urandom, $urandom, no_gap);
        end else if ($urandom_range(0, 19) == 0) begin
          push_request(KIND_UPSERT, random_key(), random_word(), random_word(), no_gap);
        end else begin
          push_request(KIND_UPSERT, key_pool[$urandom_range(0, key_pool.size() - 1)],
                       random_word(), random_word(), no_gap);
        end
      end
    end

    // Drain, then wait for any stray response to show up.
    req_ch.valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
